>>> hdl/aecb_pkg.sv
// Shared types, register indexes and AES round functions for the block cipher.
package aecb_pkg;

  typedef logic [3:0] rk_idx_t;
  localparam rk_idx_t Nr128 = 4'd10;
  localparam rk_idx_t Nr256 = 4'd14;
  localparam int unsigned NumRk = 15;

  localparam logic [2:0] RegOpMode = 3'd0;
  localparam logic [2:0] RegKey0   = 3'd1;
  localparam logic [2:0] RegKey1   = 3'd2;
  localparam logic [2:0] RegKey2   = 3'd3;
  localparam logic [2:0] RegKey3   = 3'd4;
  localparam logic [2:0] RegIvHigh = 3'd5;
  localparam logic [2:0] RegIvLow  = 3'd6;

  typedef struct packed {
    logic         dec;
    logic         cbc;
    logic         wide;
    logic         last;
    logic [127:0] blk;
  } item_t;

  typedef struct packed {
    logic         load;
    logic [127:0] value;
  } iv_load_t;

  typedef logic [7:0] sbox_t [256];

  localparam sbox_t SBOX = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic sbox_t invert_box(sbox_t f);
    sbox_t r;
    for (int i = 0; i < 256; i++) begin
      r[f[i]] = 8'(i);
    end
    return r;
  endfunction

  localparam sbox_t ISBOX = invert_box(SBOX);

  function automatic logic [7:0] xt(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] sub_bytes(logic [127:0] s, logic inv);
    logic [127:0] r;
    for (int i = 0; i < 16; i++) begin
      r[8*i +: 8] = inv ? ISBOX[s[8*i +: 8]] : SBOX[s[8*i +: 8]];
    end
    return r;
  endfunction

  function automatic logic [127:0] shift_rows(logic [127:0] s, logic inv);
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        if (inv) begin
          r[127-8*(i+4*((c+i)&3)) -: 8] = s[127-8*(i+4*c) -: 8];
        end else begin
          r[127-8*(i+4*c) -: 8] = s[127-8*(i+4*((c+i)&3)) -: 8];
        end
      end
    end
    return r;
  endfunction

  function automatic logic [127:0] mix_cols(logic [127:0] s, logic inv);
    logic [127:0] r;
    logic [7:0]   a [4];
    logic [7:0]   x2 [4];
    logic [7:0]   x4 [4];
    logic [7:0]   x8 [4];
    logic [7:0]   m9 [4];
    logic [7:0]   mb [4];
    logic [7:0]   md [4];
    logic [7:0]   me [4];
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        a[i]  = s[127-8*(i+4*c) -: 8];
        x2[i] = xt(a[i]);
        x4[i] = xt(x2[i]);
        x8[i] = xt(x4[i]);
        m9[i] = x8[i] ^ a[i];
        mb[i] = x8[i] ^ x2[i] ^ a[i];
        md[i] = x8[i] ^ x4[i] ^ a[i];
        me[i] = x8[i] ^ x4[i] ^ x2[i];
      end
      if (inv) begin
        r[127-8*(4*c)   -: 8] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
        r[127-8*(4*c+1) -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
        r[127-8*(4*c+2) -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
        r[127-8*(4*c+3) -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
      end else begin
        r[127-8*(4*c)   -: 8] = x2[0] ^ x2[1] ^ a[1] ^ a[2] ^ a[3];
        r[127-8*(4*c+1) -: 8] = a[0] ^ x2[1] ^ x2[2] ^ a[2] ^ a[3];
        r[127-8*(4*c+2) -: 8] = a[0] ^ a[1] ^ x2[2] ^ x2[3] ^ a[3];
        r[127-8*(4*c+3) -: 8] = x2[0] ^ a[0] ^ a[1] ^ a[2] ^ x2[3];
      end
    end
    return r;
  endfunction

endpackage

>>> hdl/aecb_front.sv
// Input side: accepts blocks, tags them with the current mode and queues them.
module aecb_front import aecb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // block_high, block_low
  input  logic         s_axis_tlast,   // last_block
  input  logic [2:0]   op_mode_i,
  output logic         q_valid_o,
  output item_t        q_item_o,
  input  logic         q_pop_i
);

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  item_t      new_item;

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid & s_axis_tready;
  assign q_valid_o     = (cnt_q != 2'd0);
  assign q_item_o      = mem_q[rd_ptr_q];

  always_comb begin
    new_item.dec  = op_mode_i[0];
    new_item.cbc  = op_mode_i[1];
    new_item.wide = op_mode_i[2];
    new_item.last = s_axis_tlast;
    new_item.blk  = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = q_pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

>>> hdl/aecb_keyexp.sv
// Key expansion: builds the round-key store one round key per cycle.
module aecb_keyexp import aecb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic         wide_i,
  input  logic [255:0] key_i,
  input  rk_idx_t      rd_idx_i,
  output logic [127:0] rd_key_o,
  output logic         busy_o
);

  logic [127:0] rk_q [NumRk];
  logic         pend_q, run_q, wide_q;
  rk_idx_t      idx_q;
  logic [7:0]   rcon_q;
  logic [127:0] win_a_q, win_b_q;

  logic [31:0]  w, t;
  logic [31:0]  n0, n1, n2, n3;
  logic [127:0] base, nk;
  logic         rot, copy;
  rk_idx_t      nr_last;

  always_comb begin
    w       = win_b_q[31:0];
    rot     = !wide_q || !idx_q[0];
    copy    = wide_q && (idx_q == 4'd1);
    nr_last = wide_q ? Nr256 : Nr128;
    base    = wide_q ? win_a_q : win_b_q;
    if (rot) begin
      t = {SBOX[w[23:16]] ^ rcon_q, SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
    end else begin
      t = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    end
    n0 = base[127:96] ^ t;
    n1 = base[95:64] ^ n0;
    n2 = base[63:32] ^ n1;
    n3 = base[31:0] ^ n2;
    nk = {n0, n1, n2, n3};
  end

  assign rd_key_o = rk_q[rd_idx_i];
  assign busy_o   = pend_q | run_q | start_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b1;
      run_q  <= 1'b0;
      wide_q <= 1'b0;
      idx_q  <= '0;
      rcon_q <= 8'h01;
    end else if (start_i) begin
      pend_q <= 1'b1;
      run_q  <= 1'b0;
    end else if (pend_q) begin
      pend_q <= 1'b0;
      run_q  <= 1'b1;
      wide_q <= wide_i;
      idx_q  <= 4'd1;
      rcon_q <= 8'h01;
    end else if (run_q) begin
      idx_q <= idx_q + 4'd1;
      if (!copy && rot) begin
        rcon_q <= xt(rcon_q);
      end
      if (idx_q == nr_last) begin
        run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!start_i && pend_q) begin
      rk_q[0] <= key_i[255:128];
      win_a_q <= key_i[255:128];
      win_b_q <= wide_i ? key_i[127:0] : key_i[255:128];
    end else if (!start_i && run_q) begin
      if (copy) begin
        rk_q[idx_q] <= win_b_q;
      end else begin
        rk_q[idx_q] <= nk;
        win_a_q     <= win_b_q;
        win_b_q     <= nk;
      end
    end
  end

endmodule

>>> hdl/aecb_back.sv
// Round engine: runs one queued block through the rounds, applies chaining, holds the result.
module aecb_back import aecb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_valid_i,
  input  item_t        q_item_i,
  output logic         q_pop_o,
  input  logic         kbusy_i,
  output rk_idx_t      rk_idx_o,
  input  logic [127:0] rk_i,
  input  iv_load_t     iv_wr_i,
  input  logic [127:0] iv_i,
  output logic         m_valid_o,
  input  logic         m_ready_i,
  output logic [127:0] m_data_o,
  output logic         m_last_o
);

  logic         busy_q, dec_q, cbc_q, last_q, ovalid_q, olast_q;
  rk_idx_t      kidx_q, nr_q;
  logic [127:0] st_q, in_q, chain_q, odata_q;

  logic         load, fin, out_free, step;
  rk_idx_t      nr_in;
  logic [127:0] enc_t, enc_r, dec_t, dec_r, rnd, res, pre;

  always_comb begin
    load     = !busy_q && q_valid_i && !kbusy_i;
    nr_in    = q_item_i.wide ? Nr256 : Nr128;
    rk_idx_o = busy_q ? kidx_q : (q_item_i.dec ? nr_in : 4'd0);
    fin      = dec_q ? (kidx_q == 4'd0) : (kidx_q == nr_q);
    enc_t    = shift_rows(sub_bytes(st_q, 1'b0), 1'b0);
    enc_r    = (fin ? enc_t : mix_cols(enc_t, 1'b0)) ^ rk_i;
    dec_t    = sub_bytes(shift_rows(st_q, 1'b1), 1'b1) ^ rk_i;
    dec_r    = fin ? dec_t : mix_cols(dec_t, 1'b1);
    rnd      = dec_q ? dec_r : enc_r;
    res      = rnd ^ ((cbc_q && dec_q) ? chain_q : '0);
    out_free = !ovalid_q || m_ready_i;
    step     = busy_q && (!fin || out_free);
    pre      = q_item_i.blk ^ ((q_item_i.cbc && !q_item_i.dec) ? chain_q : '0);
  end

  assign q_pop_o   = load;
  assign m_valid_o = ovalid_q;
  assign m_data_o  = odata_q;
  assign m_last_o  = olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      kidx_q   <= '0;
      ovalid_q <= 1'b0;
      chain_q  <= '0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        kidx_q <= q_item_i.dec ? nr_in - 4'd1 : 4'd1;
      end else if (step) begin
        kidx_q <= dec_q ? kidx_q - 4'd1 : kidx_q + 4'd1;
        if (fin) begin
          busy_q <= 1'b0;
        end
      end
      if (step && fin) begin
        ovalid_q <= 1'b1;
      end else if (m_ready_i) begin
        ovalid_q <= 1'b0;
      end
      if (iv_wr_i.load) begin
        chain_q <= iv_wr_i.value;
      end else if (step && fin) begin
        if (last_q) begin
          chain_q <= iv_i;
        end else if (cbc_q) begin
          chain_q <= dec_q ? in_q : res;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      st_q   <= pre ^ rk_i;
      in_q   <= q_item_i.blk;
      dec_q  <= q_item_i.dec;
      cbc_q  <= q_item_i.cbc;
      last_q <= q_item_i.last;
      nr_q   <= nr_in;
    end else if (step) begin
      st_q <= rnd;
    end
    if (step && fin) begin
      odata_q <= res;
      olast_q <= last_q;
    end
  end

`ifndef SYNTH
  a_no_start_on_stale_keys: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> !kbusy_i) else $error("block started during key expansion");
  a_round_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (kidx_q <= nr_q)) else $error("round index past last round");
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && fin && !out_free) |=> $stable(st_q) && busy_q)
    else $error("state moved while result stalled");
  a_no_pop_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !q_pop_o) else $error("queue popped while engine busy");
`endif

endmodule

>>> hdl/aes_ecb_cbc_block_cipher.sv
// AES-128/256 ECB/CBC block cipher top level: configuration registers and block wiring.
// In the round engine each block gets the initial key addition when it is loaded, then one
// round per step on the single shared round unit. A new block is taken only after the last
// one has finished, in every mode, so in CBC encryption no block starts before the previous
// ciphertext is known; the two-entry input queue and the output register keep both stream
// sides moving while the engine works. Writing op_mode or any key word restarts the key
// expansion, during which no new block starts.
module aes_ecb_cbc_block_cipher import aecb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [63:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // block_high, block_low
  input  logic         s_axis_tlast,   // last_block
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // result_high, result_low
  output logic         m_axis_tlast    // result_last
);

  logic [2:0]   op_mode_q;
  logic [63:0]  key_q [4];
  logic [63:0]  iv_high_q, iv_low_q;
  logic         kstart;
  iv_load_t     iv_wr;

  logic         q_valid, q_pop, kbusy;
  item_t        q_item;
  rk_idx_t      rk_idx;
  logic [127:0] rk, m_data;

  always_comb begin
    kstart      = 1'b0;
    iv_wr.load  = 1'b0;
    iv_wr.value = {iv_high_q, iv_low_q};
    if (cfg_we_i) begin
      case (cfg_idx_i) inside
        RegOpMode, RegKey0, RegKey1, RegKey2, RegKey3: kstart = 1'b1;
        RegIvHigh: begin
          iv_wr.load  = 1'b1;
          iv_wr.value = {cfg_wdata_i, iv_low_q};
        end
        RegIvLow: begin
          iv_wr.load  = 1'b1;
          iv_wr.value = {iv_high_q, cfg_wdata_i};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_mode_q <= '0;
      key_q     <= '{default: '0};
      iv_high_q <= '0;
      iv_low_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegOpMode: op_mode_q <= cfg_wdata_i[2:0];
        RegKey0:   key_q[0]  <= cfg_wdata_i;
        RegKey1:   key_q[1]  <= cfg_wdata_i;
        RegKey2:   key_q[2]  <= cfg_wdata_i;
        RegKey3:   key_q[3]  <= cfg_wdata_i;
        RegIvHigh: iv_high_q <= cfg_wdata_i;
        RegIvLow:  iv_low_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  aecb_front u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .op_mode_i (op_mode_q),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  aecb_keyexp u_keyexp (
    .clk_i,
    .rst_ni,
    .start_i  (kstart),
    .wide_i   (op_mode_q[2]),
    .key_i    ({key_q[0], key_q[1], key_q[2], key_q[3]}),
    .rd_idx_i (rk_idx),
    .rd_key_o (rk),
    .busy_o   (kbusy)
  );

  aecb_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .kbusy_i   (kbusy),
    .rk_idx_o  (rk_idx),
    .rk_i      (rk),
    .iv_wr_i   (iv_wr),
    .iv_i      ({iv_high_q, iv_low_q}),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_data),
    .m_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {m_data[63:0], m_data[127:64]};

endmodule

>>> verif/aes_ecb_cbc_block_cipher_tb.sv
// Self-checking testbench for the AES ECB/CBC block cipher, with its own AES and chaining model.
module aes_ecb_cbc_block_cipher_tb;
  import aecb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] RegUnused = 3'd7;
  localparam logic [2:0] ModeDec   = 3'b001;
  localparam logic [2:0] ModeCbc   = 3'b010;
  localparam logic [2:0] ModeWide  = 3'b100;
  localparam int         StallLimit = 4000;
  localparam int         DrainCycles = 40;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        last;
  } cipher_out_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [63:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;   // block_high, block_low
  logic         s_axis_tlast = 1'b0; // last_block
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;        // result_high, result_low
  logic         m_axis_tlast;        // result_last

  aes_ecb_cbc_block_cipher dut (.*);

  always #1 clk_i = ~clk_i;

  logic [7:0]  fwd_sub [256];
  logic [7:0]  inv_sub [256];
  logic [2:0]  mode_q;
  logic [63:0] key_q [4];
  logic [63:0] iv_hi_q, iv_lo_q;
  logic [63:0] chain_q [2];
  cipher_out_t result_q [$];
  int          errors = 0;
  bit          gaps_on = 1'b1;
  int          hold_cycles = 0;
  int          stall_left = 0;
  int          quiet_cycles = 0;

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      b = b >> 1;
    end
    return p;
  endfunction

  function automatic logic [7:0] rol8(logic [7:0] v, int k);
    return (v << k) | (v >> (8 - k));
  endfunction

  function automatic void build_sub_tables();
    logic [7:0] inv, s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      for (int e = 0; e < 254; e++) inv = gmul(inv, 8'(x));
      if (x == 0) inv = 8'h00;
      s = inv ^ rol8(inv, 1) ^ rol8(inv, 2) ^ rol8(inv, 3) ^ rol8(inv, 4) ^ 8'h63;
      fwd_sub[x] = s;
      inv_sub[s] = 8'(x);
    end
  endfunction

  function automatic cipher_out_t cipher_block(logic [63:0] hi, logic [63:0] lo, logic last);
    logic [7:0]  rk [240];
    logic [7:0]  st [16];
    logic [7:0]  tmp [16];
    logic [7:0]  w [4];
    logic [7:0]  a [4];
    logic [7:0]  rcon, f;
    logic [63:0] rh, rl, din_hi, din_lo;
    logic        dec, cbc, wide;
    int          nk, rounds;
    cipher_out_t res;
    dec = mode_q[0];
    cbc = mode_q[1];
    wide = mode_q[2];
    nk = wide ? 8 : 4;
    rounds = wide ? 14 : 10;
    rcon = 8'h01;
    din_hi = hi;
    din_lo = lo;
    for (int k = 0; k < 4; k++)
      for (int b = 0; b < 8; b++) rk[8*k+b] = key_q[k][63-8*b -: 8];
    for (int i = nk; i < 4 * (rounds + 1); i++) begin
      for (int j = 0; j < 4; j++) w[j] = rk[4*(i-1)+j];
      if (i % nk == 0) begin
        f = w[0];
        w[0] = fwd_sub[w[1]] ^ rcon;
        w[1] = fwd_sub[w[2]];
        w[2] = fwd_sub[w[3]];
        w[3] = fwd_sub[f];
        rcon = gmul(rcon, 8'h02);
      end else if (nk == 8 && i % nk == 4) begin
        for (int j = 0; j < 4; j++) w[j] = fwd_sub[w[j]];
      end
      for (int j = 0; j < 4; j++) rk[4*i+j] = rk[4*(i-nk)+j] ^ w[j];
    end
    if (cbc && !dec) begin
      hi ^= chain_q[0];
      lo ^= chain_q[1];
    end
    for (int b = 0; b < 8; b++) begin
      st[b] = hi[63-8*b -: 8];
      st[8+b] = lo[63-8*b -: 8];
    end
    if (!dec) begin
      for (int i = 0; i < 16; i++) st[i] ^= rk[i];
      for (int r = 1; r <= rounds; r++) begin
        for (int i = 0; i < 16; i++) tmp[i] = fwd_sub[st[i]];
        for (int c = 0; c < 4; c++)
          for (int i = 0; i < 4; i++) st[i+4*c] = tmp[i+4*((c+i)&3)];
        if (r != rounds) begin
          for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) a[i] = st[4*c+i];
            st[4*c]   = gmul(a[0], 2) ^ gmul(a[1], 3) ^ a[2] ^ a[3];
            st[4*c+1] = a[0] ^ gmul(a[1], 2) ^ gmul(a[2], 3) ^ a[3];
            st[4*c+2] = a[0] ^ a[1] ^ gmul(a[2], 2) ^ gmul(a[3], 3);
            st[4*c+3] = gmul(a[0], 3) ^ a[1] ^ a[2] ^ gmul(a[3], 2);
          end
        end
        for (int i = 0; i < 16; i++) st[i] ^= rk[16*r+i];
      end
    end else begin
      for (int i = 0; i < 16; i++) st[i] ^= rk[16*rounds+i];
      for (int r = rounds - 1; r >= 0; r--) begin
        for (int c = 0; c < 4; c++)
          for (int i = 0; i < 4; i++) tmp[i+4*((c+i)&3)] = st[i+4*c];
        for (int i = 0; i < 16; i++) st[i] = inv_sub[tmp[i]] ^ rk[16*r+i];
        if (r != 0) begin
          for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) a[i] = st[4*c+i];
            st[4*c]   = gmul(a[0], 14) ^ gmul(a[1], 11) ^ gmul(a[2], 13) ^ gmul(a[3], 9);
            st[4*c+1] = gmul(a[0], 9) ^ gmul(a[1], 14) ^ gmul(a[2], 11) ^ gmul(a[3], 13);
            st[4*c+2] = gmul(a[0], 13) ^ gmul(a[1], 9) ^ gmul(a[2], 14) ^ gmul(a[3], 11);
            st[4*c+3] = gmul(a[0], 11) ^ gmul(a[1], 13) ^ gmul(a[2], 9) ^ gmul(a[3], 14);
          end
        end
      end
    end
    for (int b = 0; b < 8; b++) begin
      rh[63-8*b -: 8] = st[b];
      rl[63-8*b -: 8] = st[8+b];
    end
    if (cbc) begin
      if (dec) begin
        rh ^= chain_q[0];
        rl ^= chain_q[1];
        chain_q[0] = din_hi;
        chain_q[1] = din_lo;
      end else begin
        chain_q[0] = rh;
        chain_q[1] = rl;
      end
    end
    if (last) begin
      chain_q[0] = iv_hi_q;
      chain_q[1] = iv_lo_q;
    end
    res.hi = rh;
    res.lo = rl;
    res.last = last;
    return res;
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    s_axis_tvalid <= 1'b0;
    wait (result_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegOpMode: mode_q = data[2:0];
      RegKey0:   key_q[0] = data;
      RegKey1:   key_q[1] = data;
      RegKey2:   key_q[2] = data;
      RegKey3:   key_q[3] = data;
      RegIvHigh: begin
        iv_hi_q = data;
        chain_q[0] = iv_hi_q;
        chain_q[1] = iv_lo_q;
      end
      RegIvLow: begin
        iv_lo_q = data;
        chain_q[0] = iv_hi_q;
        chain_q[1] = iv_lo_q;
      end
      default: ;
    endcase
  endtask

  task automatic send_block(logic [63:0] hi, logic [63:0] lo, logic last);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tdata <= {lo, hi};
    s_axis_tlast <= last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    result_q.push_back(cipher_block(hi, lo, last));
  endtask

  task automatic load_setting(logic [2:0] mode, logic [63:0] k0, logic [63:0] k1,
                              logic [63:0] k2, logic [63:0] k3,
                              logic [63:0] ivh, logic [63:0] ivl);
    write_reg(RegOpMode, {61'd0, mode});
    write_reg(RegKey0, k0);
    write_reg(RegKey1, k1);
    write_reg(RegKey2, k2);
    write_reg(RegKey3, k3);
    write_reg(RegIvHigh, ivh);
    write_reg(RegIvLow, ivl);
  endtask

  task automatic test_directed();
    send_block('0, '0, 1'b0);
    send_block('1, '1, 1'b1);
    load_setting(ModeCbc, 64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, '1, '1,
                 64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 1'b0);
    send_block(64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51, 1'b1);
    send_block('1, '0, 1'b0);
    write_reg(RegOpMode, {61'd0, ModeCbc | ModeDec});
    send_block('0, '1, 1'b0);
    write_reg(RegIvLow, '1);
    send_block('1, '1, 1'b1);
    write_reg(RegKey2, '0);
    write_reg(RegUnused, '1);
    send_block('0, '0, 1'b0);
    for (int m = 0; m < 8; m++) begin
      write_reg(RegOpMode, 64'(m));
      send_block('1, '0, 1'b0);
      send_block(64'h0123456789abcdef, 64'hfedcba9876543210, m[0]);
    end
  endtask

  task automatic test_random_messages(int n_items);
    int sent, len;
    logic [2:0] mode;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 5))
        0:       mode = 3'd0;
        1:       mode = 3'd7;
        default: mode = 3'($urandom_range(0, 7));
      endcase
      load_setting(mode, rand_word(), rand_word(), rand_word(), rand_word(),
                   rand_word(), rand_word());
      repeat ($urandom_range(1, 6)) begin
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) begin
          send_block(rand_word(), rand_word(),
                     (i == len - 1) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 15) == 0));
          sent++;
        end
      end
      if (sent > n_items * 3 / 4) gaps_on = 1'b0;
    end
  endtask

  task automatic test_backpressure();
    write_reg(RegOpMode, {61'd0, ModeCbc | ModeWide});
    hold_cycles = 300;
    for (int i = 0; i < 24; i++) send_block(rand_word(), rand_word(), i == 23);
  endtask

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles--;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(0, 7);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cipher_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result %h last %b", $time, m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        want = result_q.pop_front();
        if (m_axis_tdata[63:0] !== want.hi) begin
          $display("%0t: result_high expected %h actual %h", $time, want.hi, m_axis_tdata[63:0]);
          errors++;
        end
        if (m_axis_tdata[127:64] !== want.lo) begin
          $display("%0t: result_low expected %h actual %h", $time, want.lo,
                   m_axis_tdata[127:64]);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: result_last expected %b actual %b", $time, want.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("aes_ecb_cbc_block_cipher regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    build_sub_tables();
    mode_q = '0;
    for (int k = 0; k < 4; k++) key_q[k] = '0;
    iv_hi_q = '0;
    iv_lo_q = '0;
    chain_q[0] = '0;
    chain_q[1] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random_messages(1800);
    s_axis_tvalid <= 1'b0;
    wait (result_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("aes_ecb_cbc_block_cipher regression: pass");
    end else begin
      $display("aes_ecb_cbc_block_cipher regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/aecb_pkg.sv
hdl/aecb_front.sv
hdl/aecb_keyexp.sv
hdl/aecb_back.sv
hdl/aes_ecb_cbc_block_cipher.sv
verif/aes_ecb_cbc_block_cipher_tb.sv
